FILE: design/rx_extended_tail_builder_top_defines.svh
// Assertion helpers for the checker file.
`ifndef RX_EXTENDED_TAIL_BUILDER_TOP_DEFINES_SVH
`define RX_EXTENDED_TAIL_BUILDER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RXETB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rxetb check failed");

// Check a property on every clock edge, reset included.
`define RXETB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rxetb reset check failed");

`endif

FILE: design/rxetb_pkg.sv
`timescale 1ns / 1ps

package rxetb_pkg;

  // Port widths
  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_FIELDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEST_EFFORT_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RSSI_TYPE_CODE   = 2'd2;
  localparam logic [7:0]           RSSI_CODE_RESET      = 8'd32;

  // Timestamp conversion: ticks = (t mod WRAP_US) * 2^TICK_SHIFT / TICK_DIV
  localparam int WRAP_US    = 2000000;
  localparam int TICK_SHIFT = 9;
  localparam int TICK_DIV   = 15625;
  localparam int US_W       = 21;                 // residue below WRAP_US
  localparam int MOD_V_W    = US_W + 8;           // residue * 256 + byte
  localparam int TICK_W     = 16;
  localparam int MOD_STEPS  = 8;                  // one byte of the time per step

  // Scale by reciprocal: ticks = (residue * TICK_RECIP) >> TICK_RECIP_SH.
  // TICK_RECIP = ceil(2^44 / TICK_DIV); exact for every residue below WRAP_US.
  localparam int TICK_RECIP_W  = 31;
  localparam logic [TICK_RECIP_W-1:0] TICK_RECIP = 31'd1125899907;
  localparam int TICK_RECIP_SH = 44 - TICK_SHIFT;
  localparam int TICK_PROD_W   = US_W + TICK_RECIP_W;

  // Flag byte bits and fixed bytes
  localparam logic [7:0] FLAG_CHAN_ID   = 8'h80;
  localparam logic [7:0] FLAG_RSSI      = 8'h40;
  localparam logic [7:0] FLAG_TIMESTAMP = 8'h20;
  localparam logic [7:0] FLAG_NONE      = 8'h00;
  localparam logic [7:0] THRESHOLD_NONE = 8'h00;

  typedef struct packed {
    logic [2:0] include_fields;
    logic       best_effort_time;
    logic [7:0] rssi_type_code;
  } cfg_t;

  // One tail, classified and ready to be sent
  typedef struct packed {
    logic        ch;
    logic        rs;
    logic        ts;
    logic [15:0] dev_num;
    logic [7:0]  dev_type;
    logic [7:0]  tx_type;
    logic [7:0]  rssi_code;
    logic [7:0]  rssi_byte;
    logic [TICK_W-1:0] ticks;
  } tail_desc_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_DIV,
    F_DONE
  } front_state_t;

  typedef enum logic [3:0] {
    B_FLAG,
    B_CH0,
    B_CH1,
    B_CH2,
    B_CH3,
    B_RS0,
    B_RS1,
    B_RS2,
    B_TS0,
    B_TS1
  } back_step_t;

  // Fold one more byte into the residue: (r * 256 + b) mod WRAP_US
  function automatic logic [US_W-1:0] mod_step(input logic [US_W-1:0] r,
                                               input logic [7:0] b);
    logic [MOD_V_W-1:0] v;
    logic [MOD_V_W-1:0] m;
    v = {r, b};
    for (int k = 7; k >= 0; k--) begin
      m = MOD_V_W'(WRAP_US) << k;
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[US_W-1:0];
  endfunction

endpackage

FILE: design/rxetb_front.sv
`timescale 1ns / 1ps

module rxetb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  rxetb_pkg::cfg_t                cfg,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // dev_num[15:0], dev_type[23:16], tx_type[31:24],
  // rssi_value[39:32], sync_time_us[103:40]
  input  logic [rxetb_pkg::IN_DATA_W-1:0] s_tdata,
  // rssi_valid[0], time_valid[1], time_exact[2]
  input  logic [rxetb_pkg::IN_USER_W-1:0] s_tuser,
  output logic                           push_valid,
  input  logic                           push_ready,
  output rxetb_pkg::tail_desc_t          push_desc
);
  import rxetb_pkg::*;

  front_state_t           state;
  front_state_t           state_next;
  tail_desc_t             desc;
  logic [63:0]            tshift;
  logic [US_W-1:0]        r;
  logic [2:0]             cnt;
  logic                   accept;
  logic                   in_ch;
  logic                   in_rs;
  logic                   in_ts;
  logic [US_W-1:0]        mod_out;
  logic [TICK_PROD_W-1:0] prod;

  // Classify the incoming request against the configuration
  assign accept  = s_tvalid && s_tready;
  assign in_ch   = cfg.include_fields[2];
  assign in_rs   = cfg.include_fields[1] && s_tuser[0];
  assign in_ts   = cfg.include_fields[0] && s_tuser[1] &&
                   (s_tuser[2] || cfg.best_effort_time);
  assign mod_out = mod_step(r, tshift[63:56]);
  assign prod    = TICK_PROD_W'(r) * TICK_PROD_W'(TICK_RECIP);
  assign push_desc = desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    push_valid = 1'b0;
    case (state)
      F_IDLE: begin
        s_tready = 1'b1;
      end
      F_MOD: begin
        if (cnt == 3'(MOD_STEPS - 1)) begin
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        state_next = F_DONE;
      end
      F_DONE: begin
        push_valid = 1'b1;
        s_tready   = push_ready;
        if (push_ready) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
    if (s_tvalid && s_tready) begin
      if (!(in_ch || in_rs || in_ts)) begin
        state_next = F_IDLE;
      end else if (in_ts) begin
        state_next = F_MOD;
      end else begin
        state_next = F_DONE;
      end
    end
  end

  // Capture the request, then reduce and scale the time
  always_ff @(posedge clk) begin
    if (accept) begin
      desc.ch         <= in_ch;
      desc.rs         <= in_rs;
      desc.ts         <= in_ts;
      desc.dev_num    <= s_tdata[15:0];
      desc.dev_type   <= s_tdata[23:16];
      desc.tx_type    <= s_tdata[31:24];
      desc.rssi_code  <= cfg.rssi_type_code;
      desc.rssi_byte  <= s_tdata[39:32];
      tshift          <= s_tdata[103:40];
      r               <= '0;
      cnt             <= '0;
    end else if (state == F_MOD) begin
      r      <= mod_out;
      tshift <= tshift << 8;
      cnt    <= cnt + 3'd1;
    end else if (state == F_DIV) begin
      desc.ticks <= prod[TICK_RECIP_SH+TICK_W-1:TICK_RECIP_SH];
    end
  end

endmodule

FILE: design/rxetb_queue.sv
`timescale 1ns / 1ps

module rxetb_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  rxetb_pkg::tail_desc_t push_desc,
  output logic                  head_valid,
  output rxetb_pkg::tail_desc_t head_desc,
  input  logic                  pop
);
  import rxetb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tail_desc_t        mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Store the pushed tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/rxetb_back.sv
`timescale 1ns / 1ps

module rxetb_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  rxetb_pkg::tail_desc_t           head_desc,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tail_byte[7:0]
  output logic [rxetb_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import rxetb_pkg::*;

  back_step_t  step;
  back_step_t  step_next;
  back_step_t  after;
  logic [7:0]  byte_sel;
  logic        is_last;
  logic        load;

  // Load the output register when it is empty or being drained
  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= B_FLAG;
    end else begin
      step <= step_next;
    end
  end

  // Pick the byte of the current step and the step that follows
  always_comb begin
    byte_sel = FLAG_NONE;
    is_last  = 1'b0;
    after    = B_FLAG;
    case (step)
      B_FLAG: begin
        byte_sel = (head_desc.ch ? FLAG_CHAN_ID : FLAG_NONE) |
                   (head_desc.rs ? FLAG_RSSI : FLAG_NONE) |
                   (head_desc.ts ? FLAG_TIMESTAMP : FLAG_NONE);
        after = head_desc.ch ? B_CH0 : (head_desc.rs ? B_RS0 : B_TS0);
      end
      B_CH0: begin
        byte_sel = head_desc.dev_num[7:0];
        after    = B_CH1;
      end
      B_CH1: begin
        byte_sel = head_desc.dev_num[15:8];
        after    = B_CH2;
      end
      B_CH2: begin
        byte_sel = head_desc.dev_type;
        after    = B_CH3;
      end
      B_CH3: begin
        byte_sel = head_desc.tx_type;
        is_last  = !head_desc.rs && !head_desc.ts;
        after    = head_desc.rs ? B_RS0 : B_TS0;
      end
      B_RS0: begin
        byte_sel = head_desc.rssi_code;
        after    = B_RS1;
      end
      B_RS1: begin
        byte_sel = head_desc.rssi_byte;
        after    = B_RS2;
      end
      B_RS2: begin
        byte_sel = THRESHOLD_NONE;
        is_last  = !head_desc.ts;
        after    = B_TS0;
      end
      B_TS0: begin
        byte_sel = head_desc.ticks[7:0];
        after    = B_TS1;
      end
      B_TS1: begin
        byte_sel = head_desc.ticks[TICK_W-1:TICK_W-8];
        is_last  = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
    step_next = step;
    if (load) begin
      step_next = is_last ? B_FLAG : after;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_sel;
      m_tlast <= is_last;
    end
  end

endmodule

FILE: design/rx_extended_tail_builder_top.sv
`timescale 1ns / 1ps
// Path: front capture, queue, output register; with a timestamp the front first reduces
// the time modulo WRAP_US, one time byte per step, then scales it by a reciprocal. Throughput:
// one tail byte per cycle at the output while m_tready is high; the front takes a new request
// every cycle without a timestamp while the queue has room, none during a time conversion.
// Reset (rst, synchronous, active high) empties the queue and output and restores the
// registers: include_fields 0, best_effort_time 0, rssi_type_code 32.
module rx_extended_tail_builder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rxetb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rxetb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // dev_num[15:0], dev_type[23:16], tx_type[31:24],
  // rssi_value[39:32], sync_time_us[103:40]
  input  logic [rxetb_pkg::IN_DATA_W-1:0]  s_tdata,
  // rssi_valid[0], time_valid[1], time_exact[2]
  input  logic [rxetb_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tail_byte[7:0]
  output logic [rxetb_pkg::OUT_DATA_W-1:0] m_tdata,
  // last_byte
  output logic                             m_tlast
);
  import rxetb_pkg::*;

  cfg_t        cfg;
  logic        push_valid;
  logic        push_ready;
  tail_desc_t  push_desc;
  logic        head_valid;
  tail_desc_t  head_desc;
  logic        pop;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.include_fields   <= 3'd0;
      cfg.best_effort_time <= 1'b0;
      cfg.rssi_type_code   <= RSSI_CODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INCLUDE_FIELDS:   cfg.include_fields   <= cfg_data[2:0];
        REG_BEST_EFFORT_TIME: cfg.best_effort_time <= cfg_data[0];
        REG_RSSI_TYPE_CODE:   cfg.rssi_type_code   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rxetb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  rxetb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop)
  );

  rxetb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: design/rxetb_checker.sv
`timescale 1ns / 1ps
`include "rx_extended_tail_builder_top_defines.svh"

module rxetb_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic       expect_flag;
  logic [3:0] byte_cnt;

  // Track position inside the current tail
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_flag <= 1'b1;
      byte_cnt    <= 4'd0;
    end else if (m_tvalid && m_tready) begin
      if (m_tlast) begin
        expect_flag <= 1'b1;
        byte_cnt    <= 4'd0;
      end else begin
        expect_flag <= 1'b0;
        byte_cnt    <= byte_cnt + 4'd1;
      end
    end
  end

  // A stalled byte holds
  `RXETB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Every tail opens with a flag byte and carries at least one field after it
  `RXETB_ASSERT(a_flag_first, m_tvalid && expect_flag |-> (m_tdata[7:5] != 3'd0) && (m_tdata[4:0] == 5'd0) && !m_tlast)

  // A tail never runs past ten bytes
  `RXETB_ASSERT(a_tail_len, m_tvalid |-> byte_cnt < 4'd10)

  // Reset leaves the output empty
  `RXETB_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !m_tvalid)

endmodule

bind rx_extended_tail_builder_top rxetb_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
